FILE: hdl/rtse_pkg.sv
// ----------------------------------------------------------------------------
// RSI trend engine package
// Shared widths, register indexes, reset values and small structs.
// ----------------------------------------------------------------------------
package rtse_pkg;

	// build defaults
	localparam int MAX_WINDOW_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;

	// field widths
	localparam int SYM_W      = 16;
	localparam int PER_W      = 6;
	localparam int WIN_W      = 7;
	localparam int LVL_W      = 14;
	localparam int SIZE_W     = 16;
	localparam int QTY_W      = 32;
	localparam int OQTY_W     = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register map
	localparam int NUM_REGS = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVERBOUGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OVERSOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE = 3'd5;

	localparam logic [SYM_W-1:0]  RST_SYMBOL     = 16'd0;
	localparam logic [PER_W-1:0]  RST_PERIOD     = 6'd14;
	localparam logic [WIN_W-1:0]  RST_WINDOW     = 7'd50;
	localparam logic [LVL_W-1:0]  RST_OVERBOUGHT = 14'd7000;
	localparam logic [LVL_W-1:0]  RST_OVERSOLD   = 14'd3000;
	localparam logic [SIZE_W-1:0] RST_ORDER_SIZE = 16'd100;

	// RSI full scale (100.00) and neutral value (50.00) in hundredths
	localparam logic [LVL_W-1:0] RSI_SCALE   = 14'd10000;
	localparam logic [LVL_W-1:0] RSI_NEUTRAL = 14'd5000;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// result buffer depth, also the number of bars allowed in flight
	localparam int OBUF_DEPTH = 3;

	// per-bar flags derived from the fill level before the bar
	typedef struct packed {
		logic has_prev;   // a previous close exists, a new difference forms
		logic drop_diff;  // oldest difference leaves the RSI span
		logic drop_win;   // oldest close leaves the SMA window
		logic full;       // history complete after this bar
	} rtse_upd_ctl_t;

	typedef struct packed {
		logic [LVL_W-1:0]  ob;
		logic [LVL_W-1:0]  os;
		logic [SIZE_W-1:0] size;
	} rtse_thr_t;

	typedef struct packed {
		logic              side;
		logic [OQTY_W-1:0] qty;
	} rtse_ord_t;

endpackage

FILE: hdl/rtse_ifs.sv
// ----------------------------------------------------------------------------
// RSI trend engine channels
// Valid/ready channels for incoming bars and outgoing orders.
// ----------------------------------------------------------------------------
interface rtse_bar_if import rtse_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF
) ();
	logic                    valid;
	logic                    ready;
	logic [SYM_W-1:0]        bar_symbol;
	logic [PRICE_BITS-1:0]   close_price;
	logic signed [QTY_W-1:0] position_qty;

	modport source (output valid, bar_symbol, close_price, position_qty, input ready);
	modport sink   (input valid, bar_symbol, close_price, position_qty, output ready);
endinterface

interface rtse_order_if import rtse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              order_side;
	logic [OQTY_W-1:0] order_qty;

	modport source (output valid, order_side, order_qty, input ready);
	modport sink   (input valid, order_side, order_qty, output ready);
endinterface

FILE: hdl/rtse_ring.sv
// ----------------------------------------------------------------------------
// RSI trend engine close ring
// Single-port-write, registered-read memory holding recent closes.
// ----------------------------------------------------------------------------
module rtse_ring import rtse_pkg::*; #(
	parameter int DEPTH = MAX_WINDOW_DEF,
	parameter int AW    = $clog2(MAX_WINDOW_DEF),
	parameter int DW    = PRICE_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// read-first: a read of the slot being written returns the old close
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/rtse_update.sv
// ----------------------------------------------------------------------------
// RSI trend engine running sums
// Folds the new close and the expiring terms into gain, total and SMA sums.
// ----------------------------------------------------------------------------
module rtse_update import rtse_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int SW         = PRICE_BITS_DEF + $clog2(MAX_WINDOW_DEF)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  logic                    start,
	input  rtse_upd_ctl_t           ctl,
	input  logic [PRICE_BITS-1:0]   price,
	input  logic signed [QTY_W-1:0] qty,
	input  logic [PRICE_BITS-1:0]   prev,
	input  logic [PRICE_BITS-1:0]   wdrop,
	input  logic [PRICE_BITS-1:0]   rdata,
	output logic                    eval_valid,
	output logic [PRICE_BITS-1:0]   eval_price,
	output logic signed [QTY_W-1:0] eval_qty,
	output logic [SW-1:0]           gain,
	output logic [SW-1:0]           total,
	output logic [SW-1:0]           wsum,
	output logic                    drop
);

	localparam int XW = SW + 1;

	logic                    v_s1;
	rtse_upd_ctl_t           ctl_s1;
	logic [PRICE_BITS-1:0]   price_s1;
	logic signed [QTY_W-1:0] qty_s1;
	logic [PRICE_BITS-1:0]   prev_s1;
	logic [PRICE_BITS-1:0]   wdrop_s1;
	logic [PRICE_BITS-1:0]   pnew_s1;

	logic                    v_s2;
	logic                    full_s2;
	logic [PRICE_BITS-1:0]   price_s2;
	logic signed [QTY_W-1:0] qty_s2;
	logic [PRICE_BITS-1:0]   g_add_s2;
	logic [PRICE_BITS-1:0]   g_sub_s2;
	logic [PRICE_BITS-1:0]   t_add_s2;
	logic [PRICE_BITS-1:0]   t_sub_s2;
	logic [PRICE_BITS-1:0]   w_sub_s2;

	logic                    v_s3;
	logic [PRICE_BITS-1:0]   price_s3;
	logic signed [QTY_W-1:0] qty_s3;

	logic [SW-1:0] gain_q;
	logic [SW-1:0] total_q;
	logic [SW-1:0] wsum_q;

	logic                  up_new;
	logic                  up_drop;
	logic [PRICE_BITS-1:0] mag_new;
	logic [PRICE_BITS-1:0] mag_drop;

	// stage 1: differences; rdata carries the older close of the leaving pair
	always_comb begin
		up_new   = price_s1 > prev_s1;
		mag_new  = up_new ? (price_s1 - prev_s1) : (prev_s1 - price_s1);
		up_drop  = pnew_s1 > rdata;
		mag_drop = up_drop ? (pnew_s1 - rdata) : (rdata - pnew_s1);
		if (!ctl_s1.has_prev) begin
			mag_new = '0;
		end
		if (!ctl_s1.drop_diff) begin
			mag_drop = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && full_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ctl_s1   <= ctl;
			price_s1 <= price;
			qty_s1   <= qty;
			prev_s1  <= prev;
			wdrop_s1 <= wdrop;
			pnew_s1  <= rdata;
		end
		full_s2  <= ctl_s1.full;
		price_s2 <= price_s1;
		qty_s2   <= qty_s1;
		g_add_s2 <= up_new ? mag_new : '0;
		g_sub_s2 <= up_drop ? mag_drop : '0;
		t_add_s2 <= mag_new;
		t_sub_s2 <= mag_drop;
		w_sub_s2 <= ctl_s1.drop_win ? wdrop_s1 : '0;
		price_s3 <= price_s2;
		qty_s3   <= qty_s2;
	end

	// stage 2: running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= '0;
			total_q <= '0;
			wsum_q  <= '0;
		end else if (clr) begin
			gain_q  <= '0;
			total_q <= '0;
			wsum_q  <= '0;
		end else if (v_s2) begin
			gain_q  <= SW'(XW'(gain_q) + XW'(g_add_s2) - XW'(g_sub_s2));
			total_q <= SW'(XW'(total_q) + XW'(t_add_s2) - XW'(t_sub_s2));
			wsum_q  <= SW'(XW'(wsum_q) + XW'(price_s2) - XW'(w_sub_s2));
		end
	end

	assign drop       = v_s2 && !full_s2;
	assign eval_valid = v_s3;
	assign eval_price = price_s3;
	assign eval_qty   = qty_s3;
	assign gain       = gain_q;
	assign total      = total_q;
	assign wsum       = wsum_q;

endmodule

FILE: hdl/rtse_decide.sv
// ----------------------------------------------------------------------------
// RSI trend engine decision
// Cross-multiplied RSI and SMA compares, then the buy/sell choice.
// ----------------------------------------------------------------------------
module rtse_decide import rtse_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	parameter int SW         = PRICE_BITS_DEF + $clog2(MAX_WINDOW_DEF),
	parameter int CW         = $clog2(MAX_WINDOW_DEF + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [PRICE_BITS-1:0]   price,
	input  logic signed [QTY_W-1:0] qty,
	input  logic [SW-1:0]           gain,
	input  logic [SW-1:0]           total,
	input  logic [SW-1:0]           wsum,
	input  logic [CW-1:0]           win,
	input  rtse_thr_t               thr,
	output logic                    push,
	output rtse_ord_t               ord,
	output logic                    drop
);

	localparam int MW = SW + LVL_W;
	localparam int PW = PRICE_BITS + CW;

	logic                    v_s4;
	logic [MW-1:0]           pg_s4;
	logic [MW-1:0]           pos_s4;
	logic [MW-1:0]           pob_s4;
	logic [PW-1:0]           pp_s4;
	logic [SW-1:0]           wsum_s4;
	logic                    tz_s4;
	logic signed [QTY_W-1:0] qty_s4;

	logic lt_os;
	logic gt_ob;
	logic above;
	logic below;
	logic q_zero;
	logic q_pos;
	logic buy;
	logic sell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= valid;
		end
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		pg_s4   <= MW'(gain) * MW'(RSI_SCALE);
		pos_s4  <= MW'(total) * MW'(thr.os);
		pob_s4  <= MW'(total) * MW'(thr.ob);
		pp_s4   <= PW'(price) * PW'(win);
		wsum_s4 <= wsum;
		tz_s4   <= total == '0;
		qty_s4  <= qty;
	end

	// stage 4: compares; flat market reads as neutral RSI
	always_comb begin
		lt_os  = tz_s4 ? (RSI_NEUTRAL < thr.os) : (pg_s4 < pos_s4);
		gt_ob  = tz_s4 ? (RSI_NEUTRAL > thr.ob) : (pg_s4 > pob_s4);
		above  = pp_s4 > PW'(wsum_s4);
		below  = pp_s4 < PW'(wsum_s4);
		q_zero = qty_s4 == '0;
		q_pos  = !q_zero && !qty_s4[QTY_W-1];
		buy    = q_zero && lt_os && above;
		sell   = q_pos && (gt_ob || below);
	end

	assign push     = v_s4 && (buy || sell);
	assign drop     = v_s4 && !(buy || sell);
	assign ord.side = buy ? SIDE_BUY : SIDE_SELL;
	assign ord.qty  = buy ? OQTY_W'(thr.size) : qty_s4[OQTY_W-1:0];

endmodule

FILE: hdl/rtse_obuf.sv
// ----------------------------------------------------------------------------
// RSI trend engine order buffer
// Small FIFO that decouples the decision stage from the order channel.
// ----------------------------------------------------------------------------
module rtse_obuf import rtse_pkg::*; #(
	parameter int DEPTH = OBUF_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rtse_ord_t           ord,
	output logic                pop,
	rtse_order_if.source        order
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtse_ord_t          ent_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign pop              = order.valid && order.ready;
	assign order.valid      = cnt_q != '0;
	assign order.order_side = ent_q[rd_q].side;
	assign order.order_qty  = ent_q[rd_q].qty;

	// upstream credits keep push from ever hitting a full buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= ord;
		end
	end

endmodule

FILE: hdl/rsi_trend_signal_engine.sv
// ----------------------------------------------------------------------------
// RSI trend signal engine
// RSI entry/exit with an SMA trend filter over a ring of recent closes.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat contents
//   -------   ---  -----------------------------------------------
//   bar       in   bar_symbol, close_price, position_qty
//   order     out  order_side (0 buy, 1 sell), order_qty
//   cfg       in   cfg_we, cfg_idx, cfg_wdata (write only)
//
// A bar of the selected symbol runs four read phases: the ring has one read port
// and each bar needs four closes from it (previous close, close leaving the
// SMA window, and the pair whose difference leaves the RSI span). The next
// bar is taken in the last read phase. Other bars are taken without reads.
// Orders pass the update, decision and buffer stages; up to three bars or
// orders may be outstanding, so a stalled order channel backs up into bar.
// Reset or a valid register write empties the history; no clearing pass.
// ----------------------------------------------------------------------------
module rsi_trend_signal_engine import rtse_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rtse_bar_if.sink              bar,
	rtse_order_if.source          order,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int EW  = (CW > WIN_W) ? CW : WIN_W;
	localparam int SW  = PRICE_BITS + $clog2(MAX_WINDOW);
	localparam int CRW = $clog2(OBUF_DEPTH + 1);

	// read sequence, one ring read per phase
	localparam logic [1:0] PH_PREV  = 2'd0;  // close one bar back
	localparam logic [1:0] PH_WDROP = 2'd1;  // close leaving the SMA window
	localparam logic [1:0] PH_PNEW  = 2'd2;  // newer close of leaving diff
	localparam logic [1:0] PH_POLD  = 2'd3;  // older close; new close written

	// configuration
	logic [SYM_W-1:0]  symbol_q;
	logic [PER_W-1:0]  period_q;
	logic [WIN_W-1:0]  window_q;
	logic [LVL_W-1:0]  ob_q;
	logic [LVL_W-1:0]  os_q;
	logic [SIZE_W-1:0] size_q;
	logic              cfg_hit;

	// sequencer
	logic                    busy_q;
	logic [1:0]              phase_q;
	logic [PRICE_BITS-1:0]   price_q;
	logic signed [QTY_W-1:0] qty_q;
	logic [PRICE_BITS-1:0]   prev_q;
	logic [PRICE_BITS-1:0]   wdrop_q;
	logic [AW-1:0]           head_q;
	logic [CW-1:0]           fill_q;
	logic [CRW-1:0]          credit_q;

	logic          slot_free;
	logic          last_ph;
	logic          take;
	logic          take_match;
	logic [CRW-1:0] cred_left;

	logic [EW-1:0] per_x;
	logic [EW-1:0] win_x;
	logic [CW-1:0] per_eff;
	logic [CW-1:0] per_p1;
	logic [CW-1:0] win_eff;
	logic [CW-1:0] needed;
	logic [CW-1:0] back_k;
	logic [CW:0]   ra_x;
	logic [AW-1:0] raddr;

	logic [PRICE_BITS-1:0] rd_data;
	rtse_upd_ctl_t         ctl;
	rtse_thr_t             thr;

	logic                    ev_valid;
	logic [PRICE_BITS-1:0]   ev_price;
	logic signed [QTY_W-1:0] ev_qty;
	logic [SW-1:0]           gain;
	logic [SW-1:0]           total;
	logic [SW-1:0]           wsum;
	logic                    upd_drop;
	logic                    dec_drop;
	logic                    push;
	rtse_ord_t               ord;
	logic                    pop;

	// ---- configuration registers; any valid write also clears history ----
	assign cfg_hit = cfg_we && (cfg_idx < CFG_IDX_W'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q <= RST_SYMBOL;
			period_q <= RST_PERIOD;
			window_q <= RST_WINDOW;
			ob_q     <= RST_OVERBOUGHT;
			os_q     <= RST_OVERSOLD;
			size_q   <= RST_ORDER_SIZE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SYMBOL:     symbol_q <= cfg_wdata[SYM_W-1:0];
				REG_PERIOD:     period_q <= cfg_wdata[PER_W-1:0];
				REG_WINDOW:     window_q <= cfg_wdata[WIN_W-1:0];
				REG_OVERBOUGHT: ob_q     <= cfg_wdata[LVL_W-1:0];
				REG_OVERSOLD:   os_q     <= cfg_wdata[LVL_W-1:0];
				REG_ORDER_SIZE: size_q   <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign thr.ob   = ob_q;
	assign thr.os   = os_q;
	assign thr.size = size_q;

	// ---- effective period/window, clamped into the ring's reach ----
	always_comb begin
		per_x = EW'(period_q);
		if (per_x == '0) begin
			per_x = EW'(1);
		end else if (per_x > EW'(MAX_WINDOW - 1)) begin
			per_x = EW'(MAX_WINDOW - 1);
		end
		win_x = EW'(window_q);
		if (win_x == '0) begin
			win_x = EW'(1);
		end else if (win_x > EW'(MAX_WINDOW)) begin
			win_x = EW'(MAX_WINDOW);
		end
		per_eff = CW'(per_x);
		win_eff = CW'(win_x);
		per_p1  = per_eff + CW'(1);
		needed  = (per_p1 > win_eff) ? per_p1 : win_eff;
	end

	// ---- ring address: k closes back from the slot the new close takes ----
	always_comb begin
		case (phase_q)
			PH_PREV:  back_k = CW'(1);
			PH_WDROP: back_k = win_eff;
			PH_PNEW:  back_k = per_eff;
			PH_POLD:  back_k = per_p1;
			default:  back_k = CW'(1);
		endcase
		if ((CW+1)'(head_q) >= (CW+1)'(back_k)) begin
			ra_x = (CW+1)'(head_q) - (CW+1)'(back_k);
		end else begin
			ra_x = (CW+1)'(head_q) + (CW+1)'(MAX_WINDOW) - (CW+1)'(back_k);
		end
		raddr = ra_x[AW-1:0];
	end

	// flags from the fill level before the bar; fill saturates at needed,
	// which is at least window and period+1, so they stay right once full
	assign ctl.has_prev  = fill_q != '0;
	assign ctl.drop_diff = fill_q >= per_p1;
	assign ctl.drop_win  = fill_q >= win_eff;
	assign ctl.full      = ((CW+1)'(fill_q) + (CW+1)'(1)) >= (CW+1)'(needed);

	// ---- bar handshake and credits ----
	// a credit stands for a bar in flight or an order waiting in the buffer
	assign last_ph    = busy_q && (phase_q == PH_POLD);
	assign slot_free  = !busy_q || last_ph;
	assign cred_left  = credit_q - CRW'(pop) - CRW'(upd_drop) - CRW'(dec_drop);
	assign bar.ready  = slot_free && (cred_left < CRW'(OBUF_DEPTH));
	assign take       = bar.valid && bar.ready;
	assign take_match = take && (bar.bar_symbol == symbol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			phase_q  <= PH_PREV;
			head_q   <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			credit_q <= cred_left + CRW'(take_match);
			if (take_match) begin
				busy_q  <= 1'b1;
				phase_q <= PH_PREV;
			end else if (last_ph) begin
				busy_q  <= 1'b0;
				phase_q <= PH_PREV;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
			end
			if (cfg_hit) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (last_ph) begin
				head_q <= (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
				if (fill_q < needed) begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			price_q <= PRICE_BITS'(bar.close_price);
			qty_q   <= bar.position_qty;
		end
		if (busy_q && (phase_q == PH_WDROP)) begin
			prev_q <= rd_data;
		end
		if (busy_q && (phase_q == PH_PNEW)) begin
			wdrop_q <= rd_data;
		end
	end

	// ---- datapath ----
	rtse_ring #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (PRICE_BITS)
	) u_ring (
		.clk   (clk),
		.we    (last_ph),
		.waddr (head_q),
		.wdata (price_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	rtse_update #(
		.PRICE_BITS (PRICE_BITS),
		.SW         (SW)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (cfg_hit),
		.start      (last_ph),
		.ctl        (ctl),
		.price      (price_q),
		.qty        (qty_q),
		.prev       (prev_q),
		.wdrop      (wdrop_q),
		.rdata      (rd_data),
		.eval_valid (ev_valid),
		.eval_price (ev_price),
		.eval_qty   (ev_qty),
		.gain       (gain),
		.total      (total),
		.wsum       (wsum),
		.drop       (upd_drop)
	);

	rtse_decide #(
		.PRICE_BITS (PRICE_BITS),
		.SW         (SW),
		.CW         (CW)
	) u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (ev_valid),
		.price  (ev_price),
		.qty    (ev_qty),
		.gain   (gain),
		.total  (total),
		.wsum   (wsum),
		.win    (win_eff),
		.thr    (thr),
		.push   (push),
		.ord    (ord),
		.drop   (dec_drop)
	);

	rtse_obuf #(
		.DEPTH (OBUF_DEPTH)
	) u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ord    (ord),
		.pop    (pop),
		.order  (order)
	);

endmodule
